@@ rtl/core/lru_fully_associative_tag_table_unit_macros.svh @@
// ----------------------------------------------------------------------------
// LRU tag table assertion macros
// Concurrent check wrappers; NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef LRU_FULLY_ASSOCIATIVE_TAG_TABLE_UNIT_MACROS_SVH
`define LRU_FULLY_ASSOCIATIVE_TAG_TABLE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define LFAT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lfat check failed");
// next-cycle implication
`define LFAT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lfat check failed");
`else
`define LFAT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LFAT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/lfat_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU tag table package
// Shared defaults, codes, result and status types.
// ----------------------------------------------------------------------------
package lfat_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 64;
	localparam int STAMP_BITS_DEF = 32;

	// fixed field widths of the stream payload
	localparam int KEY_W  = 64;
	localparam int SLOT_W = 4;
	localparam int RES_W  = 8;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} state_t;

	// hit in the lowest bit
	typedef struct packed {
		logic              replaced;
		logic [SLOT_W-1:0] slot;
		logic              hit;
	} result_t;

	typedef struct packed {
		logic busy;
		logic full;
	} status_t;

endpackage

@@ rtl/core/lru_fully_associative_tag_table_unit.sv @@
// ----------------------------------------------------------------------------
// LRU fully associative tag table
// Tag lookup and insert with timestamp least-recently-used replacement.
// ----------------------------------------------------------------------------
// One transaction at a time: a lookup reads the filled slots one per cycle
// through the single read port of the entry store and stops at the first
// match. An insert into a table that is not full needs no scan; an insert
// into a full table scans every slot for the oldest stamp. The input is not
// ready during a scan and comes back the cycle after the result moves to the
// output register. A result waits in an output register, so the next
// transaction can start while it is still held.
module lru_fully_associative_tag_table_unit #(
	parameter int ENTRIES    = lfat_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = lfat_pkg::KEY_BITS_DEF,
	parameter int STAMP_BITS = lfat_pkg::STAMP_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [lfat_pkg::KEY_W-1:0] s_axis_tdata,  // [63:0] key
	input  logic [0:0]                 s_axis_tuser,  // [0] op
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [lfat_pkg::RES_W-1:0] m_axis_tdata   // [0] hit, [4:1] slot,
	                                                  // [5] replaced, [7:6] zero
);

	import lfat_pkg::*;

	logic    res_valid, res_ready;
	result_t res;
	status_t stat;
	logic    out_valid_q;
	result_t out_res_q;

	// sequencer with compare unit and entry store
	lfat_scan #(
		.ENTRIES   (ENTRIES),
		.KEY_BITS  (KEY_BITS),
		.STAMP_BITS(STAMP_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (op_t'(s_axis_tuser[0])),
		.in_key   (s_axis_tdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.stat     (stat)
	);

	// output register
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = RES_W'(out_res_q);

	// checks
	`include "lru_fully_associative_tag_table_unit_macros.svh"

	`LFAT_ASSERT_NXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`LFAT_ASSERT_IMP(a_hit_not_evict, clk, arst_n, res_valid, !(res.hit && res.replaced))
	`LFAT_ASSERT_IMP(a_evict_only_full, clk, arst_n, res_valid && res.replaced, stat.full)
	`LFAT_ASSERT_NXT(a_result_held, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res))

endmodule

@@ rtl/core/lfat_mem.sv @@
// ----------------------------------------------------------------------------
// LRU tag table entry store
// Key and stamp arrays, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lfat_mem #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 64,
	parameter int STAMP_BITS = 32
) (
	input  logic                       clk,
	input  logic [$clog2(ENTRIES)-1:0] rd_addr,
	output logic [KEY_BITS-1:0]        rd_key,
	output logic [STAMP_BITS-1:0]      rd_stamp,
	input  logic [$clog2(ENTRIES)-1:0] wr_addr,
	input  logic                       key_we,
	input  logic                       stamp_we,
	input  logic [KEY_BITS-1:0]        wr_key,
	input  logic [STAMP_BITS-1:0]      wr_stamp
);

	logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
	logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];

	// write port
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (stamp_we) begin
			stamp_mem[wr_addr] <= wr_stamp;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_key   <= key_mem[rd_addr];
		rd_stamp <= stamp_mem[rd_addr];
	end

endmodule

@@ rtl/core/lfat_cmp.sv @@
// ----------------------------------------------------------------------------
// LRU tag table compare unit
// Shared equality / less-than comparator used by every scan step.
// ----------------------------------------------------------------------------
module lfat_cmp #(
	parameter int W = 64
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         eq,
	output logic         lt
);

	// unsigned compare
	assign eq = (a == b);
	assign lt = (a < b);

endmodule

@@ rtl/core/lfat_scan.sv @@
// ----------------------------------------------------------------------------
// LRU tag table sequencer
// Walks the entry store one slot per cycle for key match or oldest stamp, then
// writes stamp and, on insert, key (none on a lookup miss), hands result on.
// ----------------------------------------------------------------------------
module lfat_scan #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 64,
	parameter int STAMP_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  lfat_pkg::op_t             in_op,
	input  logic [lfat_pkg::KEY_W-1:0] in_key,
	output logic                      res_valid,
	input  logic                      res_ready,
	output lfat_pkg::result_t         res,
	output lfat_pkg::status_t         stat
);

	import lfat_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (KEY_BITS > STAMP_BITS) ? KEY_BITS : STAMP_BITS;

	state_t                state_q, nxt_state;
	op_t                   op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [CNT_W-1:0]      fill_q;
	logic [STAMP_BITS-1:0] clock_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic                  pend_s1;
	logic [IDX_W-1:0]      cmp_idx_s1;
	logic [IDX_W-1:0]      tgt_q;
	logic [STAMP_BITS-1:0] best_q;
	logic                  hit_q;
	logic                  repl_q;

	logic [KEY_BITS-1:0]   rd_key;
	logic [STAMP_BITS-1:0] rd_stamp;
	logic [CMP_W-1:0]      cmp_a, cmp_b;
	logic                  cmp_eq, cmp_lt;
	logic                  is_lookup, is_full, accept;
	logic [CNT_W-1:0]      limit;
	logic                  issue, last, match, take_min;

	assign is_lookup = (op_q == OP_LOOKUP);
	assign is_full   = (fill_q == CNT_W'(ENTRIES));
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign limit     = is_lookup ? fill_q : CNT_W'(ENTRIES);
	assign issue     = (state_q == ST_SCAN) && (rd_idx_q < limit);
	assign last      = pend_s1 && ((CNT_W'(cmp_idx_s1) + CNT_W'(1)) == limit);

	// entry store
	lfat_mem #(
		.ENTRIES   (ENTRIES),
		.KEY_BITS  (KEY_BITS),
		.STAMP_BITS(STAMP_BITS)
	) u_mem (
		.clk     (clk),
		.rd_addr (rd_idx_q[IDX_W-1:0]),
		.rd_key  (rd_key),
		.rd_stamp(rd_stamp),
		.wr_addr (tgt_q),
		.key_we  ((state_q == ST_WRITE) && !is_lookup),
		.stamp_we(state_q == ST_WRITE),
		.wr_key  (key_q),
		.wr_stamp(clock_q)
	);

	// shared comparator: key match on lookup, stamp order on eviction
	assign cmp_a = is_lookup ? CMP_W'(rd_key) : CMP_W'(rd_stamp);
	assign cmp_b = is_lookup ? CMP_W'(key_q) : CMP_W'(best_q);

	lfat_cmp #(
		.W(CMP_W)
	) u_cmp (
		.a (cmp_a),
		.b (cmp_b),
		.eq(cmp_eq),
		.lt(cmp_lt)
	);

	assign match    = pend_s1 && is_lookup && cmp_eq;
	assign take_min = pend_s1 && !is_lookup && ((cmp_idx_s1 == '0) || cmp_lt);

	// next state
	always_comb begin
		nxt_state = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_op == OP_LOOKUP) begin
						nxt_state = (fill_q == '0) ? ST_DONE : ST_SCAN;
					end else begin
						nxt_state = is_full ? ST_SCAN : ST_WRITE;
					end
				end
			end
			ST_SCAN: begin
				if (match) begin
					nxt_state = ST_WRITE;
				end else if (last) begin
					nxt_state = is_lookup ? ST_DONE : ST_WRITE;
				end
			end
			ST_WRITE: nxt_state = ST_DONE;
			ST_DONE: begin
				if (res_ready) begin
					nxt_state = ST_IDLE;
				end
			end
			default: nxt_state = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		res_valid    = (state_q == ST_DONE);
		res.hit      = hit_q;
		res.slot     = SLOT_W'(tgt_q);
		res.replaced = repl_q;
		stat.busy    = (state_q != ST_IDLE);
		stat.full    = is_full;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			clock_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= nxt_state;
			if (accept) begin
				pend_s1 <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				pend_s1 <= issue;
			end
			if (state_q == ST_WRITE) begin
				clock_q <= clock_q + STAMP_BITS'(1);
				if (!is_lookup && !repl_q) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
		end
	end

	// scan datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= in_op;
			key_q    <= in_key[KEY_BITS-1:0];
			rd_idx_q <= '0;
			hit_q    <= 1'b0;
			repl_q   <= (in_op == OP_INSERT) && is_full;
			tgt_q    <= (in_op == OP_INSERT) ? fill_q[IDX_W-1:0] : '0;
		end else if (state_q == ST_SCAN) begin
			cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
			if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (match) begin
				tgt_q <= cmp_idx_s1;
				hit_q <= 1'b1;
			end
			if (take_min) begin
				best_q <= rd_stamp;
				tgt_q  <= cmp_idx_s1;
			end
		end
	end

endmodule

@@ sim/lru_tag_table_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU tag table checker
// Watches both stream channels, keeps its own copy of the tag table and the
// access clock, predicts the result of every accepted request and compares
// each returned result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lru_tag_table_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [63:0] key
	input  logic [0:0] s_axis_tuser,   // [0] op
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,   // [0] hit, [4:1] slot, [5] replaced
	output int         mismatches,
	output int         outstanding
);
	import lfat_pkg::*;

	localparam int ENTRIES    = ENTRIES_DEF;
	localparam int KEY_BITS   = KEY_BITS_DEF;
	localparam int STAMP_BITS = STAMP_BITS_DEF;
	localparam int MAX_REPORTS = 200;

	// shadow copy of the table
	logic [KEY_BITS-1:0]   tag_keys [ENTRIES];
	logic [STAMP_BITS-1:0] tag_stamps [ENTRIES];
	int                    tag_fill = 0;
	logic [STAMP_BITS-1:0] access_clock = '0;

	result_t predicted_results [$];
	int      fails = 0;

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	// one request against the shadow table; updates stamps, keys and fill
	function automatic result_t table_access(op_t op, logic [KEY_BITS-1:0] key);
		result_t               r;
		int                    victim;
		int                    i;
		logic [STAMP_BITS-1:0] oldest;
		r = '0;
		victim = 0;
		if (op == OP_LOOKUP) begin
			// only filled slots take part; lowest match wins
			for (i = 0; i < tag_fill; i++) begin
				if (tag_keys[i] == key) begin
					tag_stamps[i] = access_clock;
					access_clock  = access_clock + 1'b1;
					r.hit  = 1'b1;
					r.slot = 4'(i);
					break;
				end
			end
			return r;
		end
		if (tag_fill < ENTRIES) begin
			victim   = tag_fill;
			tag_fill = tag_fill + 1;
		end else begin
			// first slot with the smallest stamp
			oldest = tag_stamps[0];
			for (i = 1; i < ENTRIES; i++) begin
				if (tag_stamps[i] < oldest) begin
					oldest = tag_stamps[i];
					victim = i;
				end
			end
			r.replaced = 1'b1;
		end
		tag_keys[victim]   = key;
		tag_stamps[victim] = access_clock;
		access_clock       = access_clock + 1'b1;
		r.slot = 4'(victim);
		return r;
	endfunction

	// result side first, then the request accepted at the same edge
	always @(posedge clk) begin : watch
		result_t got;
		result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[5:0];
				if (predicted_results.size() == 0) begin
					fails++;
					if (fails <= MAX_REPORTS)
						$display("%0t: unexpected result hit=%0b slot=%0d replaced=%0b",
							$time, got.hit, got.slot, got.replaced);
				end else begin
					want = predicted_results.pop_front();
					if (got.hit !== want.hit || got.slot !== want.slot
						|| got.replaced !== want.replaced) begin
						fails++;
						if (fails <= MAX_REPORTS)
							$display("%0t: expected hit=%0b slot=%0d replaced=%0b, got hit=%0b slot=%0d replaced=%0b",
								$time, want.hit, want.slot, want.replaced,
								got.hit, got.slot, got.replaced);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predicted_results.push_back(table_access(op_t'(s_axis_tuser[0]), s_axis_tdata));
		end
		mismatches  <= fails;
		outstanding <= predicted_results.size();
	end

endmodule

@@ sim/tb_lru_fully_associative_tag_table_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU tag table testbench
// Drives lookups and inserts into the tag table with random gaps on the
// request side and random stalls on the result side. A short directed run
// fills the table and exercises misses, duplicates and replacement, then
// random phases mix keys from a small reused set with fresh keys.
// ----------------------------------------------------------------------------
module tb_lru_fully_associative_tag_table_unit;
	import lfat_pkg::*;

	localparam int  POOL_SIZE  = 20;
	localparam int  PHASES     = 8;
	localparam int  PHASE_LEN  = 116;
	localparam int  HOLD_LEN   = 300;
	localparam int  DRAIN_WAIT = 40;
	localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] KEY_ALT1 = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [63:0] KEY_ALT0 = 64'h5555_5555_5555_5555;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata  = '0;  // [63:0] key
	logic [0:0]  s_axis_tuser  = '0;  // [0] op
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // [0] hit, [4:1] slot, [5] replaced, [7:6] zero
	int          mismatches;
	int          outstanding;

	bit          tx_calm   = 1'b0;
	bit          rx_calm   = 1'b0;
	bit          long_hold = 1'b0;
	logic [63:0] key_pool [POOL_SIZE];

	lru_fully_associative_tag_table_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	lru_tag_table_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	initial begin
		#4_000_000;
		$display("lru_fully_associative_tag_table_unit: mismatch");
		$finish;
	end

	// result side: random stalls, calm stretches and one long hold-off
	initial begin : result_sink
		int stall;
		forever begin
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				long_hold = 1'b0;
			end
			stall = rx_calm ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// one request transaction, after a random gap
	task automatic send_request(input op_t op, input logic [63:0] key);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= key;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// stop offering and wait for every predicted result
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// mostly reused keys so lookups hit and inserts duplicate
	function automatic logic [63:0] pick_key(int reuse_pct);
		if ($urandom_range(0, 99) < reuse_pct)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return {$urandom, $urandom};
	endfunction

	initial begin : stimulus
		op_t op;
		int  p;
		int  n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, hits, miss, duplicate, fill, replacement
		send_request(OP_LOOKUP, '0);
		send_request(OP_INSERT, '0);
		send_request(OP_INSERT, KEY_ONES);
		send_request(OP_LOOKUP, KEY_ONES);
		send_request(OP_LOOKUP, '0);
		send_request(OP_LOOKUP, KEY_ALT1);
		send_request(OP_INSERT, KEY_ONES);
		send_request(OP_LOOKUP, KEY_ONES);
		send_request(OP_INSERT, KEY_ALT0);
		for (n = 0; n < 12; n++)
			send_request(OP_INSERT, {$urandom, $urandom});
		send_request(OP_INSERT, KEY_ALT1);
		send_request(OP_LOOKUP, KEY_ALT0);
		send_request(OP_INSERT, {$urandom, $urandom});
		send_request(OP_LOOKUP, KEY_ALT1);
		wait_drained();

		key_pool[0] = '0;
		key_pool[1] = KEY_ONES;
		key_pool[2] = KEY_ALT1;
		key_pool[3] = KEY_ALT0;
		for (n = 4; n < POOL_SIZE; n++)
			key_pool[n] = {$urandom, $urandom};

		// random phases with varying idle patterns on both sides
		for (p = 0; p < PHASES; p++) begin
			tx_calm = (p % 4 == 1) || (p % 4 == 2);
			rx_calm = (p % 4 == 1) || (p % 4 == 3);
			if (p == 2)
				long_hold = 1'b1;
			for (n = 0; n < PHASE_LEN; n++) begin
				// churn the key set now and then
				if ($urandom_range(0, 15) == 0)
					key_pool[$urandom_range(0, POOL_SIZE - 1)] = {$urandom, $urandom};
				if ($urandom_range(0, 9) < 4) begin
					op = OP_INSERT;
					send_request(op, pick_key(90));
				end else begin
					op = OP_LOOKUP;
					send_request(op, pick_key(85));
				end
			end
			wait_drained();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("lru_fully_associative_tag_table_unit: match");
		else
			$display("lru_fully_associative_tag_table_unit: mismatch");
		$finish;
	end

endmodule
